// ----- hdl/brse_pkg.sv -----
// ----------------------------------------------------------------------------
// brse_pkg
// shared types and constants of the bitmap row span extractor
// ----------------------------------------------------------------------------
package brse_pkg;

   localparam int WORD_BITS  = 16;   // pixels in one input word
   localparam int IDX_W      = 4;    // pixel index inside a word
   localparam int POS_W      = 5;    // scan position, 0 .. WORD_BITS
   localparam int COL_W      = 8;    // icon column
   localparam int ROW_W      = 8;    // icon row
   localparam int DIM_W      = 9;    // width and height registers
   localparam int COORD_W    = 16;   // screen coordinates
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_ICON_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ICON_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y    = 2'd3;

   // result of one search of the shared find-first unit
   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] idx;
   } hit_type;

   // one span as it waits in the pending or output register
   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] y;
      logic                      colour;
   } span_type;

endpackage

// ----- hdl/brse_if.sv -----
// ----------------------------------------------------------------------------
// brse_if
// valid/ready channels: pixel words in, spans out
// ----------------------------------------------------------------------------
interface brse_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [brse_pkg::WORD_BITS-1:0]       pixel_word;
   logic                                 plane;
   logic [brse_pkg::ROW_W-1:0]           row;
   logic [brse_pkg::IDX_W-1:0]           word_index;

   modport source (output valid, output pixel_word, output plane, output row,
                   output word_index, input ready);
   modport sink   (input valid, input pixel_word, input plane, input row,
                   input word_index, output ready);
endinterface

interface brse_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [brse_pkg::COORD_W-1:0]  span_start_x;
   logic signed [brse_pkg::COORD_W-1:0]  span_end_x;
   logic signed [brse_pkg::COORD_W-1:0]  span_y;
   logic                                 span_colour;
   logic                                 last_span;

   modport source (output valid, output span_start_x, output span_end_x,
                   output span_y, output span_colour, output last_span,
                   input ready);
   modport sink   (input valid, input span_start_x, input span_end_x,
                   input span_y, input span_colour, input last_span,
                   output ready);
endinterface

// ----- hdl/bitmap_row_span_extractor.sv -----
// ----------------------------------------------------------------------------
// bitmap_row_span_extractor
// turns one-bit icon rows into horizontal spans of set pixels
// ----------------------------------------------------------------------------
//  channel  dir  handshake            content
//  req_if   in   valid/ready          pixel_word, plane, row, word_index
//  rsp_if   out  valid/ready          span_start_x, span_end_x, span_y,
//                                     span_colour, last_span
//  csr_*    in   csr_write_en         csr_index, csr_write_data
//
//  a word is loaded while idle, then scanned with one find-first search per run
//  edge that the search hits and a closing search, then flushed, as long as
//  rsp_if is ready; a row outside the icon is only loaded and the next word
//  can follow at once; the single find-first unit paces the scan
//  reset is synchronous: registers go to width 32, height 32, origin 0,
//  no run open
//  req_if.ready is high only while idle; a stalled rsp_if holds the scan at
//  the next span, which waits in a pending register behind the output register
// ----------------------------------------------------------------------------
module bitmap_row_span_extractor #(
   parameter int MAX_ICON_WIDTH  = 256,
   parameter int MAX_ICON_HEIGHT = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   brse_req_if.sink                          req_if,
   brse_rsp_if.source                        rsp_if,
   input  logic                              csr_write_en,
   input  logic [brse_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [brse_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   localparam int WB = brse_pkg::WORD_BITS;
   localparam int CW = brse_pkg::COL_W;
   localparam int DW = brse_pkg::DIM_W;
   localparam int XW = brse_pkg::COORD_W;

   // configuration registers
   logic [DW-1:0] icon_width_ff,  icon_width_in;
   logic [DW-1:0] icon_height_ff, icon_height_in;
   logic [XW-1:0] origin_x_ff,    origin_x_in;
   logic [XW-1:0] origin_y_ff,    origin_y_in;

   // sequencer and word being scanned
   logic [1:0]                   state_ff, state_in;
   logic [WB-1:0]                bits_ff, bits_in;         // column order, masked
   logic [brse_pkg::IDX_W-1:0]   widx_ff, widx_in;
   logic                         word_end_ff, word_end_in; // width ends at word end
   logic                         colour_ff, colour_in;
   logic [XW-1:0]                y_ff, y_in;
   logic [brse_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                         run_open_ff, run_open_in;
   logic [CW-1:0]                run_start_ff, run_start_in;

   // pending span and output register
   logic                         pend_valid_ff, pend_valid_in;
   brse_pkg::span_type           pend_ff, pend_in;
   logic                         out_valid_ff, out_valid_in;
   brse_pkg::span_type           out_ff, out_in;
   logic                         out_last_ff, out_last_in;

   // combinational helpers
   logic [DW-1:0]                w_eff, h_eff;
   logic [CW-1:0]                req_base, base_col;
   logic [WB-1:0]                col_mask;
   logic [WB-1:0]                req_cols;
   logic [WB-1:0]                search_vec;
   brse_pkg::hit_type            hit;
   logic                         out_free;
   logic                         span_room;
   logic                         new_span;
   logic [CW-1:0]                new_end_col;

   // clamp the dimension registers to the supported icon size
   always_comb begin
      w_eff = (int'(icon_width_ff) > MAX_ICON_WIDTH) ? DW'(MAX_ICON_WIDTH) : icon_width_ff;
      h_eff = (int'(icon_height_ff) > MAX_ICON_HEIGHT) ? DW'(MAX_ICON_HEIGHT)
                                                       : icon_height_ff;
   end

   // columns of the incoming word that lie inside the icon width
   always_comb begin
      req_base = {req_if.word_index, 4'b0000};
      for (int i = 0; i < WB; i++) begin
         col_mask[i] = (({1'b0, req_base} + DW'(i)) < w_eff);
      end
   end

   // incoming pixels in column order, leftmost column at bit 0
   assign req_cols = {<<{req_if.pixel_word}};

   // searching for a clear column while a run is open, else for a set one
   assign search_vec = run_open_ff ? ~bits_ff : bits_ff;
   assign base_col   = {widx_ff, 4'b0000};

   brse_find_first u_find (
      .vec (search_vec),
      .pos (pos_ff),
      .hit (hit)
   );

   assign out_free  = !out_valid_ff || rsp_if.ready;
   assign span_room = !pend_valid_ff || out_free;

   // csr writes
   always_comb begin
      icon_width_in  = icon_width_ff;
      icon_height_in = icon_height_ff;
      origin_x_in    = origin_x_ff;
      origin_y_in    = origin_y_ff;
      if (csr_write_en) begin
         case (csr_index)
            brse_pkg::CSR_ICON_WIDTH:  icon_width_in  = csr_write_data[DW-1:0];
            brse_pkg::CSR_ICON_HEIGHT: icon_height_in = csr_write_data[DW-1:0];
            brse_pkg::CSR_ORIGIN_X:    origin_x_in    = csr_write_data[XW-1:0];
            brse_pkg::CSR_ORIGIN_Y:    origin_y_in    = csr_write_data[XW-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      bits_in       = bits_ff;
      widx_in       = widx_ff;
      word_end_in   = word_end_ff;
      colour_in     = colour_ff;
      y_in          = y_ff;
      pos_in        = pos_ff;
      run_open_in   = run_open_ff;
      run_start_in  = run_start_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      new_span      = 1'b0;
      new_end_col   = '0;

      // output transfer frees the register
      if (out_valid_ff && rsp_if.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               bits_in     = req_cols & col_mask;
               widx_in     = req_if.word_index;
               word_end_in = (w_eff == ({1'b0, req_base} + DW'(WB)));
               colour_in   = req_if.plane;
               y_in        = origin_y_ff + {{(XW-brse_pkg::ROW_W){1'b0}}, req_if.row};
               pos_in      = '0;
               if ({1'b0, req_if.row} >= h_eff) begin
                  // row outside the icon: no spans, drop the carried run
                  run_open_in = 1'b0;
               end else begin
                  // first word of a row never inherits a run
                  run_open_in = (req_if.word_index == '0) ? 1'b0 : run_open_ff;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (run_open_ff) begin
               if (hit.found) begin
                  // first clear column closes the run
                  if (span_room) begin
                     new_span    = 1'b1;
                     new_end_col = base_col + {4'b0000, hit.idx} - CW'(1);
                     run_open_in = 1'b0;
                     pos_in      = {1'b0, hit.idx};
                  end
               end else if (word_end_ff) begin
                  // run reaches the row's last column
                  if (span_room) begin
                     new_span    = 1'b1;
                     new_end_col = base_col + CW'(WB - 1);
                     run_open_in = 1'b0;
                     state_in    = ST_FLUSH;
                  end
               end else begin
                  // run carries into the next word
                  state_in = ST_FLUSH;
               end
            end else begin
               if (hit.found) begin
                  run_open_in  = 1'b1;
                  run_start_in = base_col + {4'b0000, hit.idx};
                  pos_in       = {1'b0, hit.idx} + brse_pkg::POS_W'(1);
               end else begin
                  state_in = ST_FLUSH;
               end
            end

            // a new span pushes the pending one out as not last
            if (new_span) begin
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_in       = pend_ff;
                  out_last_in  = 1'b0;
               end
               pend_valid_in   = 1'b1;
               pend_in.start_x = origin_x_ff + {{(XW-CW){1'b0}}, run_start_ff};
               pend_in.end_x   = origin_x_ff + {{(XW-CW){1'b0}}, new_end_col};
               pend_in.y       = y_ff;
               pend_in.colour  = colour_ff;
            end
         end
         ST_FLUSH: begin
            // the span still pending is the word's last one
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_in        = pend_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         icon_width_ff  <= DW'(32);
         icon_height_ff <= DW'(32);
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         state_ff       <= ST_IDLE;
         run_open_ff    <= 1'b0;
         run_start_ff   <= '0;
         pend_valid_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         icon_width_ff  <= icon_width_in;
         icon_height_ff <= icon_height_in;
         origin_x_ff    <= origin_x_in;
         origin_y_ff    <= origin_y_in;
         state_ff       <= state_in;
         run_open_ff    <= run_open_in;
         run_start_ff   <= run_start_in;
         pend_valid_ff  <= pend_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      bits_ff     <= bits_in;
      widx_ff     <= widx_in;
      word_end_ff <= word_end_in;
      colour_ff   <= colour_in;
      y_ff        <= y_in;
      pos_ff      <= pos_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign req_if.ready        = (state_ff == ST_IDLE);
   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.span_start_x = out_ff.start_x;
   assign rsp_if.span_end_x   = out_ff.end_x;
   assign rsp_if.span_y       = out_ff.y;
   assign rsp_if.span_colour  = out_ff.colour;
   assign rsp_if.last_span    = out_last_ff;

endmodule

// ----- hdl/brse_find_first.sv -----
// ----------------------------------------------------------------------------
// brse_find_first
// shared search unit: first set bit at or after a scan position
// ----------------------------------------------------------------------------
module brse_find_first (
   input  logic [brse_pkg::WORD_BITS-1:0] vec,   // bit 0 is the leftmost column
   input  logic [brse_pkg::POS_W-1:0]     pos,
   output brse_pkg::hit_type              hit
);

   logic [brse_pkg::WORD_BITS-1:0] masked;

   always_comb begin
      masked    = vec & ({brse_pkg::WORD_BITS{1'b1}} << pos);
      hit.found = 1'b0;
      hit.idx   = '0;
      // lowest index wins
      for (int i = brse_pkg::WORD_BITS - 1; i >= 0; i--) begin
         if (masked[i]) begin
            hit.found = 1'b1;
            hit.idx   = brse_pkg::IDX_W'(i);
         end
      end
   end

endmodule

// ----- sim/bitmap_row_span_extractor_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_row_span_extractor_test
// self-checking bench: pixel words go in through a bursty driver, spans come
// out through a stalling monitor and are matched in order against spans that
// a behavioral row scanner in this file computes for every accepted word
// ----------------------------------------------------------------------------
module bitmap_row_span_extractor_test;

   localparam logic PLANE_MASK   = 1'b0;   // drawn black
   localparam logic PLANE_DATA   = 1'b1;   // drawn white
   localparam int   MAX_WIDTH    = 256;
   localparam int   MAX_HEIGHT   = 256;
   localparam int   RANDOM_WORDS = 140;
   localparam int   DRAIN_CYCLES = 24;
   localparam int   QUIET_LIMIT  = 2000;   // cycles without any transfer

   // one pixel word as it goes into the block
   typedef struct packed {
      logic [brse_pkg::WORD_BITS-1:0] pixel_word;
      logic                           plane;
      logic [brse_pkg::ROW_W-1:0]     row;
      logic [brse_pkg::IDX_W-1:0]     word_index;
   } pixel_word_type;

   // one span as it comes out of the block
   typedef struct packed {
      logic signed [brse_pkg::COORD_W-1:0] start_x;
      logic signed [brse_pkg::COORD_W-1:0] end_x;
      logic signed [brse_pkg::COORD_W-1:0] y;
      logic                                colour;
      logic                                last_span;
   } screen_span_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                            csr_write_en   = 1'b0;
   logic [brse_pkg::CSR_IDX_W-1:0]  csr_index      = '0;
   logic [brse_pkg::CSR_DATA_W-1:0] csr_write_data = '0;

   brse_req_if req_ch ();
   brse_rsp_if rsp_ch ();

   bitmap_row_span_extractor dut (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_ch),
      .rsp_if         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // scanner state: register copies plus the run carried between words
   // ---------------------------------------------------------------------
   logic [brse_pkg::DIM_W-1:0]          icon_width_cfg  = 9'd32;
   logic [brse_pkg::DIM_W-1:0]          icon_height_cfg = 9'd32;
   logic signed [brse_pkg::COORD_W-1:0] origin_x_cfg    = '0;
   logic signed [brse_pkg::COORD_W-1:0] origin_y_cfg    = '0;
   logic                                run_open        = 1'b0;
   logic [brse_pkg::COL_W-1:0]          run_start_col   = '0;

   pixel_word_type  pending_words [$];   // waiting for the driver
   screen_span_type expected_spans [$];  // oldest first
   int              mismatches = 0;

   function automatic screen_span_type make_span(input int first_col, input int last_col,
                                                 input pixel_word_type wd);
      screen_span_type sp;
      sp.start_x   = origin_x_cfg + brse_pkg::COORD_W'(first_col);
      sp.end_x     = origin_x_cfg + brse_pkg::COORD_W'(last_col);
      sp.y         = origin_y_cfg + brse_pkg::COORD_W'(wd.row);
      sp.colour    = wd.plane;
      sp.last_span = 1'b0;
      return sp;
   endfunction

   // scan one accepted word left to right and queue the spans it closes
   function automatic void extract_spans(input pixel_word_type wd);
      int              w;
      int              h;
      int              col;
      logic            lit;
      screen_span_type closed [$];
      w = (icon_width_cfg > MAX_WIDTH) ? MAX_WIDTH : int'(icon_width_cfg);
      h = (icon_height_cfg > MAX_HEIGHT) ? MAX_HEIGHT : int'(icon_height_cfg);
      // a new row start drops whatever the previous row left open
      if (wd.word_index == '0)
         run_open = 1'b0;
      // rows past the height are silent and kill a carried run
      if (int'(wd.row) >= h) begin
         run_open = 1'b0;
         return;
      end
      for (int i = 0; i < brse_pkg::WORD_BITS; i++) begin
         col = int'(wd.word_index) * brse_pkg::WORD_BITS + i;
         // columns past the width read as clear
         lit = wd.pixel_word[brse_pkg::WORD_BITS-1-i] && (col < w);
         if (lit) begin
            if (!run_open) begin
               run_open      = 1'b1;
               run_start_col = brse_pkg::COL_W'(col);
            end
            // the last counted column of the row always closes the run
            if (col + 1 == w) begin
               closed.push_back(make_span(int'(run_start_col), col, wd));
               run_open = 1'b0;
            end
         end else if (run_open) begin
            closed.push_back(make_span(int'(run_start_col), col - 1, wd));
            run_open = 1'b0;
         end
      end
      if (closed.size() != 0)
         closed[closed.size()-1].last_span = 1'b1;
      foreach (closed[k])
         expected_spans.push_back(closed[k]);
   endfunction

   // ---------------------------------------------------------------------
   // driver: bursts of transfers with random gaps in between
   // ---------------------------------------------------------------------
   pixel_word_type driven_word;
   int             burst_left = 0;
   int             gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            extract_spans(driven_word);
         // the slot frees up when the current word was taken or none was up
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               driven_word           = pending_words.pop_front();
               req_ch.valid         <= 1'b1;
               req_ch.pixel_word    <= driven_word.pixel_word;
               req_ch.plane         <= driven_word.plane;
               req_ch.row           <= driven_word.row;
               req_ch.word_index    <= driven_word.word_index;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: ready follows a rotating stall pattern, every transfer checked
   // ---------------------------------------------------------------------
   logic [15:0]     stall_pattern = 16'hFFFF;
   logic [3:0]      stall_pos     = '0;
   screen_span_type got_span;
   screen_span_type want_span;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_span.start_x   = rsp_ch.span_start_x;
            got_span.end_x     = rsp_ch.span_end_x;
            got_span.y         = rsp_ch.span_y;
            got_span.colour    = rsp_ch.span_colour;
            got_span.last_span = rsp_ch.last_span;
            if (expected_spans.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected span x %0d..%0d y %0d colour %0b last %0b",
                           $realtime, got_span.start_x, got_span.end_x, got_span.y,
                           got_span.colour, got_span.last_span);
               mismatches++;
            end else begin
               want_span = expected_spans.pop_front();
               if (got_span.start_x !== want_span.start_x ||
                   got_span.end_x !== want_span.end_x ||
                   got_span.y !== want_span.y ||
                   got_span.colour !== want_span.colour ||
                   got_span.last_span !== want_span.last_span) begin
                  if (mismatches < 10)
                     $display(
                        "%0t: want x %0d..%0d y %0d c %0b l %0b, got x %0d..%0d y %0d c %0b l %0b",
                        $realtime, want_span.start_x, want_span.end_x, want_span.y,
                        want_span.colour, want_span.last_span, got_span.start_x,
                        got_span.end_x, got_span.y, got_span.colour,
                        got_span.last_span);
                  mismatches++;
               end
            end
         end
         rsp_ch.ready <= stall_pattern[stall_pos];
         stall_pos    <= stall_pos + 1'b1;
         // new pattern each lap: always ready, mostly ready, coin flip, mostly stalled
         if (stall_pos == 4'd15) begin
            case ($urandom_range(0, 3))
               0:       stall_pattern <= 16'hFFFF;
               1:       stall_pattern <= 16'($urandom) | 16'($urandom);
               2:       stall_pattern <= 16'($urandom);
               default: stall_pattern <= 16'($urandom) & 16'($urandom);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: too long without any transfer ends the run
   // ---------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || csr_write_en || (req_ch.valid && req_ch.ready) ||
          (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_word(input logic [brse_pkg::WORD_BITS-1:0] pixels,
                            input logic plane, input int row, input int word_index);
      pixel_word_type wd;
      wd.pixel_word = pixels;
      wd.plane      = plane;
      wd.row        = brse_pkg::ROW_W'(row);
      wd.word_index = brse_pkg::IDX_W'(word_index);
      pending_words.push_back(wd);
   endtask

   // all four registers, one write per cycle; the block is idle here
   task automatic configure(input logic [brse_pkg::DIM_W-1:0] width,
                            input logic [brse_pkg::DIM_W-1:0] height,
                            input logic [brse_pkg::COORD_W-1:0] ox,
                            input logic [brse_pkg::COORD_W-1:0] oy);
      logic [brse_pkg::CSR_IDX_W-1:0]  reg_index [4];
      logic [brse_pkg::CSR_DATA_W-1:0] reg_value [4];
      reg_index = '{brse_pkg::CSR_ICON_WIDTH, brse_pkg::CSR_ICON_HEIGHT,
                    brse_pkg::CSR_ORIGIN_X, brse_pkg::CSR_ORIGIN_Y};
      reg_value = '{brse_pkg::CSR_DATA_W'(width), brse_pkg::CSR_DATA_W'(height), ox, oy};
      icon_width_cfg  = width;
      icon_height_cfg = height;
      origin_x_cfg    = ox;
      origin_y_cfg    = oy;
      for (int r = 0; r < 4; r++) begin
         @(posedge clock);
         csr_write_en   <= 1'b1;
         csr_index      <= reg_index[r];
         csr_write_data <= reg_value[r];
      end
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // hold off until every word went in and every span came back, then let
   // a trailing silent word finish its scan
   task automatic settle();
      do
         @(negedge clock);
      while (pending_words.size() != 0 || req_ch.valid || expected_spans.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [brse_pkg::WORD_BITS-1:0] random_pixels();
      case ($urandom_range(0, 5))
         0:       return 16'hFFFF;
         1:       return 16'h0000;
         2:       return 16'($urandom) & 16'($urandom);
         3:       return 16'($urandom) | 16'($urandom);
         4:       return $urandom_range(0, 1) ? 16'h5555 : 16'hAAAA;
         default: return 16'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin
      int   random_words;
      int   width;
      int   height;
      int   w_eff;
      int   h_eff;
      int   row_count;
      int   word_count;
      int   row;
      logic plane;
      logic [brse_pkg::COORD_W-1:0] ox;
      logic [brse_pkg::COORD_W-1:0] oy;

      req_ch.valid      = 1'b0;
      req_ch.pixel_word = '0;
      req_ch.plane      = PLANE_MASK;
      req_ch.row        = '0;
      req_ch.word_index = '0;
      rsp_ch.ready      = 1'b0;
      random_words      = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words under the reset geometry: 32 x 32 at origin 0
      push_word(16'hFFFF, PLANE_MASK, 0, 0);    // run crossing a word boundary
      push_word(16'hFFFF, PLANE_DATA, 0, 1);    // ... closed at the last column
      push_word(16'h0001, PLANE_MASK, 1, 0);    // carried run then
      push_word(16'h5555, PLANE_MASK, 1, 1);    // eight more: nine spans from one word
      push_word(16'hAAAA, PLANE_DATA, 2, 0);
      push_word(16'h0000, PLANE_MASK, 3, 0);    // blank word, no span
      push_word(16'h0001, PLANE_DATA, 4, 0);
      push_word(16'hFFFF, PLANE_DATA, 200, 1);  // row past height drops the run
      push_word(16'h8000, PLANE_DATA, 4, 1);
      push_word(16'h0001, PLANE_MASK, 5, 0);
      push_word(16'hFFFF, PLANE_MASK, 5, 3);    // run carried into columns past width
      push_word(16'h0001, PLANE_MASK, 6, 0);
      push_word(16'h8000, PLANE_MASK, 7, 0);    // index zero drops the open run
      push_word(16'h0001, PLANE_MASK, 8, 0);
      push_word(16'h7FFF, PLANE_DATA, 9, 1);    // row and plane change mid-run
      push_word(16'h8001, PLANE_DATA, 31, 0);   // last row
      push_word(16'hFFFF, PLANE_DATA, 31, 15);  // last word index, past width
      settle();

      // largest geometry, coordinates wrap past the top of the range
      configure(9'd256, 9'd256, 16'h7FFF, 16'h8000);
      push_word(16'hFFFF, PLANE_MASK, 255, 14);
      push_word(16'hFFFF, PLANE_DATA, 255, 15);
      settle();

      // zero width counts no column
      configure(9'd0, 9'd511, 16'h8000, 16'h7FFF);
      push_word(16'hFFFF, PLANE_MASK, 0, 0);
      settle();

      // width above the maximum is clamped, zero height is silent
      configure(9'd300, 9'd0, 16'h0000, 16'h0000);
      push_word(16'hFFFF, PLANE_DATA, 10, 15);
      settle();

      // single column, single row
      configure(9'd1, 9'd1, 16'hFFFF, 16'hFFFF);
      push_word(16'hC000, PLANE_MASK, 0, 0);
      push_word(16'h8000, PLANE_DATA, 1, 0);
      settle();

      // random geometries, each with a few well-formed rows and some noise
      while (random_words < RANDOM_WORDS) begin
         case ($urandom_range(0, 7))
            0:       width = MAX_WIDTH;
            1:       width = $urandom_range(1, 16);
            2:       width = $urandom_range(257, 511);
            3:       width = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(17, 40);
            default: width = $urandom_range(1, 64);
         endcase
         case ($urandom_range(0, 7))
            0:       height = MAX_HEIGHT;
            1:       height = $urandom_range(257, 511);
            2:       height = ($urandom_range(0, 3) == 0) ? 0 : 1;
            default: height = $urandom_range(2, 40);
         endcase
         case ($urandom_range(0, 5))
            0:       ox = 16'h7FFF;
            1:       ox = 16'h8000;
            default: ox = 16'($urandom);
         endcase
         case ($urandom_range(0, 5))
            0:       oy = 16'h7FFF;
            1:       oy = 16'h8000;
            default: oy = 16'($urandom);
         endcase
         configure(brse_pkg::DIM_W'(width), brse_pkg::DIM_W'(height), ox, oy);
         w_eff = (width > MAX_WIDTH) ? MAX_WIDTH : width;
         h_eff = (height > MAX_HEIGHT) ? MAX_HEIGHT : height;
         // wide rows are long, keep them to one row a phase
         row_count = (w_eff > 64) ? 1 : $urandom_range(1, 4);
         repeat (row_count) begin
            plane = $urandom_range(0, 1) ? PLANE_DATA : PLANE_MASK;
            if ($urandom_range(0, 5) == 0) begin
               // broken order: stray words with arbitrary position and row
               repeat ($urandom_range(1, 3)) begin
                  push_word(random_pixels(), $urandom_range(0, 1) ? PLANE_DATA : PLANE_MASK,
                            $urandom_range(0, 255), $urandom_range(0, 15));
                  random_words++;
               end
            end else begin
               if (h_eff > 0 && $urandom_range(0, 7) != 0)
                  row = $urandom_range(0, h_eff - 1);
               else
                  row = $urandom_range(0, 255);
               word_count = (w_eff == 0) ? 1 : (w_eff + brse_pkg::WORD_BITS - 1) /
                                               brse_pkg::WORD_BITS;
               for (int k = 0; k < word_count; k++)
                  push_word(random_pixels(), plane, row, k);
               random_words += word_count;
            end
         end
         settle();
      end

      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
